FILE: hdl/ffba_pkg.sv
// ffba_pkg: shared types and constants of the first-fit block allocator
// used by ffba_table, first_fit_block_allocator and ffba_checker
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 16;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

	localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_NOHEAP  = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic        free;
		logic [31:0] size;
		logic [31:0] start;
	} entry_t;

endpackage

FILE: hdl/first_fit_block_allocator.sv
// first_fit_block_allocator: heap block manager with first-fit reuse and a break pointer
// depends on ffba_pkg and ffba_table
//
// usage
//   s_axis carries one request word: tuser is the op (allocate or release),
//   tdata holds the request size and the release address
//   m_axis returns one result word per request: tdata is the payload address,
//   tuser holds the status code and the shrink flag
//   heap_limit_we / heap_limit_wdata write the heap limit, only while idle
// timing
//   a zero-size allocate or a null release skips the table walk and goes straight to finish
//   any other request walks the block table, one entry per cycle through the
//   single table read port and one shared compare, stopping at the first hit
//   one request is in work at a time; s_axis_tready is high only when idle
// reset
//   arst_n empties the table, sets the break to 0 and the heap limit to 65536;
//   the table memory needs no clearing pass
// stall
//   the result sits in the output register until taken; a new request is
//   accepted meanwhile, and its result waits until the register frees up
module first_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // request_size [31:0], release_address [63:32]
	input  logic        s_axis_tuser,   // op [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // payload_address [31:0]
	output logic [7:0]  m_axis_tuser,   // status [2:0], shrank_heap [3], zero [7:4]
	input  logic        heap_limit_we,
	input  logic [31:0] heap_limit_wdata
);

	localparam int IW = ffba_pkg::IDX_W;
	localparam int CW = ffba_pkg::CNT_W;
	localparam logic [CW-1:0] COUNT_MAX = CW'(ffba_pkg::MAX_BLOCKS);
	localparam logic [32:0] HDR33 = 33'(ffba_pkg::HEADER_BYTES);
	localparam logic [33:0] HDR34 = 34'(ffba_pkg::HEADER_BYTES);
	localparam logic [31:0] HDR32 = 32'(ffba_pkg::HEADER_BYTES);

	ffba_pkg::state_t  state_q, state_d;
	ffba_pkg::op_t     op_q;
	logic [31:0]       req_q;
	logic [31:0]       addr_q;
	logic [CW-1:0]     scan_idx_q;
	logic              rd_vld_q;
	logic [IW-1:0]     cmp_idx_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	ffba_pkg::entry_t  hit_entry_q;
	logic [CW-1:0]     count_q;
	logic [31:0]       break_q;
	logic [31:0]       limit_q;
	logic              m_valid_q;
	logic [31:0]       m_addr_q;
	ffba_pkg::status_t m_status_q;
	logic              m_shrank_q;

	ffba_pkg::entry_t  rd_data;
	logic              accept;
	logic              quick;
	logic              match;
	logic              scan_hit;
	logic              scan_miss;
	logic              rd_issue;
	logic              out_free;
	logic              finish;
	logic [33:0]       new_break;

	logic              tbl_we;
	logic [IW-1:0]     tbl_waddr;
	ffba_pkg::entry_t  tbl_wdata;
	logic              fin_count_we;
	logic [CW-1:0]     fin_count;
	logic [31:0]       fin_break;
	logic [31:0]       fin_addr;
	ffba_pkg::status_t fin_status;
	logic              fin_shrank;

	ffba_table u_table (
		.clk     (clk),
		.wr_en   (tbl_we),
		.wr_addr (tbl_waddr),
		.wr_data (tbl_wdata),
		.rd_addr (scan_idx_q[IW-1:0]),
		.rd_data (rd_data)
	);

	assign s_axis_tready = (state_q == ffba_pkg::S_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign quick         = (s_axis_tuser == ffba_pkg::OP_ALLOC) ? (s_axis_tdata[31:0] == 32'd0)
	                                                           : (s_axis_tdata[63:32] == 32'd0);
	assign out_free      = ~m_valid_q | m_axis_tready;
	assign finish        = (state_q == ffba_pkg::S_FINISH) & out_free;

	// shared compare unit
	always_comb begin
		if (op_q == ffba_pkg::OP_ALLOC) begin
			match = rd_data.free & (rd_data.size >= req_q);
		end else begin
			match = (({1'b0, rd_data.start} + HDR33) == {1'b0, addr_q});
		end
	end

	assign scan_hit  = (state_q == ffba_pkg::S_SCAN) & rd_vld_q & match;
	assign scan_miss = (state_q == ffba_pkg::S_SCAN) & ~scan_hit & (scan_idx_q >= count_q);
	assign rd_issue  = (state_q == ffba_pkg::S_SCAN) & ~scan_hit & (scan_idx_q < count_q);
	assign new_break = {2'b00, break_q} + HDR34 + {2'b00, req_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffba_pkg::S_IDLE: begin
				if (accept) begin
					state_d = quick ? ffba_pkg::S_FINISH : ffba_pkg::S_SCAN;
				end
			end
			ffba_pkg::S_SCAN: begin
				if (scan_hit | scan_miss) begin
					state_d = ffba_pkg::S_FINISH;
				end
			end
			ffba_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ffba_pkg::S_IDLE;
				end
			end
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// completion of a request
	always_comb begin
		tbl_we       = 1'b0;
		tbl_waddr    = hit_idx_q;
		tbl_wdata    = hit_entry_q;
		fin_count_we = 1'b0;
		fin_count    = count_q;
		fin_break    = break_q;
		fin_addr     = 32'd0;
		fin_status   = ffba_pkg::ST_OK;
		fin_shrank   = 1'b0;
		if (op_q == ffba_pkg::OP_ALLOC) begin
			if (req_q == 32'd0) begin
				fin_status = ffba_pkg::ST_ZERO;
			end else if (hit_q) begin
				tbl_we         = finish;
				tbl_wdata.free = 1'b0;
				fin_addr       = hit_entry_q.start + HDR32;
			end else if (new_break > {2'b00, limit_q}) begin
				fin_status = ffba_pkg::ST_NOHEAP;
			end else if (count_q == COUNT_MAX) begin
				fin_status = ffba_pkg::ST_FULL;
			end else begin
				tbl_we          = finish;
				tbl_waddr       = count_q[IW-1:0];
				tbl_wdata.free  = 1'b0;
				tbl_wdata.size  = req_q;
				tbl_wdata.start = break_q;
				fin_count_we    = 1'b1;
				fin_count       = count_q + CW'(1);
				fin_break       = new_break[31:0];
				fin_addr        = break_q + HDR32;
			end
		end else begin
			if (addr_q == 32'd0) begin
				fin_status = ffba_pkg::ST_OK;
			end else if (!hit_q) begin
				fin_status = ffba_pkg::ST_UNKNOWN;
			end else if ((CW'(hit_idx_q) + CW'(1)) == count_q) begin
				fin_count_we = 1'b1;
				fin_count    = CW'(hit_idx_q);
				fin_break    = hit_entry_q.start;
				fin_shrank   = 1'b1;
			end else begin
				tbl_we         = finish;
				tbl_wdata.free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ffba_pkg::S_IDLE;
			rd_vld_q <= 1'b0;
			hit_q    <= 1'b0;
			count_q  <= '0;
			break_q  <= 32'd0;
			limit_q  <= ffba_pkg::HEAP_LIMIT_RESET;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (heap_limit_we) begin
				limit_q <= heap_limit_wdata;
			end
			if (accept) begin
				rd_vld_q <= 1'b0;
				hit_q    <= 1'b0;
			end else if (state_q == ffba_pkg::S_SCAN) begin
				rd_vld_q <= rd_issue;
				if (scan_hit) begin
					hit_q <= 1'b1;
				end
			end
			if (finish && fin_count_we) begin
				count_q <= fin_count;
				break_q <= fin_break;
			end
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= ffba_pkg::op_t'(s_axis_tuser);
			req_q      <= s_axis_tdata[31:0];
			addr_q     <= s_axis_tdata[63:32];
			scan_idx_q <= '0;
		end else if (rd_issue) begin
			scan_idx_q <= scan_idx_q + CW'(1);
		end
		cmp_idx_q <= scan_idx_q[IW-1:0];
		if (scan_hit) begin
			hit_idx_q   <= cmp_idx_q;
			hit_entry_q <= rd_data;
		end
		if (finish) begin
			m_addr_q   <= fin_addr;
			m_status_q <= fin_status;
			m_shrank_q <= fin_shrank;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_addr_q;
	assign m_axis_tuser  = {4'b0000, m_shrank_q, m_status_q};

endmodule

FILE: hdl/ffba_table.sv
// ffba_table: block table memory, one write port and one registered read port
// depends on ffba_pkg for the entry type and the table depth
module ffba_table (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ffba_pkg::IDX_W-1:0] wr_addr,
	input  ffba_pkg::entry_t          wr_data,
	input  logic [ffba_pkg::IDX_W-1:0] rd_addr,
	output ffba_pkg::entry_t          rd_data
);

	ffba_pkg::entry_t mem_q [ffba_pkg::MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hdl/ffba_checker.sv
// ffba_checker: port-level assertions for first_fit_block_allocator
// depends on ffba_pkg; bound to the top level at the end of this file
module ffba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [7:0]  m_axis_tuser
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// one request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while busy");

	// a shrink only comes from a successful release
	a_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |->
		m_axis_tuser[2:0] == ffba_pkg::ST_OK && m_axis_tdata == 32'd0)
		else $error("shrink flag on a non-release result");

	// a payload address only comes with an ok status
	a_addr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata != 32'd0 |->
		m_axis_tuser[2:0] == ffba_pkg::ST_OK && !m_axis_tuser[3])
		else $error("payload address with failure status");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_first_fit_block_allocator.sv
// tb_first_fit_block_allocator: self-checking bench for the first-fit heap block allocator
// predicts every result from its own copy of the block table, break and heap limit
// depends on ffba_pkg and first_fit_block_allocator
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
	import ffba_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [31:0] payload;
		status_t     status;
		logic        shrank;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [31:0]   blk_start [MAX_BLOCKS];
		logic [31:0]   blk_size [MAX_BLOCKS];
		bit            blk_free [MAX_BLOCKS];
		int            blk_count;
		logic [31:0]   brk;
		logic [31:0]   heap_limit;
		alloc_result_t pending_results[$];
		int            mismatch_count;

		function new();
			blk_count = 0;
			brk = '0;
			heap_limit = HEAP_LIMIT_RESET;
			mismatch_count = 0;
		endfunction

		function logic [31:0] payload_at(int idx);
			return blk_start[idx] + 32'(HEADER_BYTES);
		endfunction

		function void note_request(op_t op, logic [31:0] sz, logic [31:0] addr);
			alloc_result_t r;
			int            hit;
			int            i;
			logic [33:0]   grown;
			r.payload = '0;
			r.status = ST_OK;
			r.shrank = 1'b0;
			hit = -1;
			if (op == OP_ALLOC) begin
				if (sz == 0) begin
					r.status = ST_ZERO;
				end else begin
					for (i = 0; i < blk_count; i++) begin
						if (blk_free[i] && blk_size[i] >= sz) begin
							hit = i;
							break;
						end
					end
					if (hit >= 0) begin
						blk_free[hit] = 1'b0;
						r.payload = payload_at(hit);
					end else begin
						grown = {2'b00, brk} + 34'(HEADER_BYTES) + {2'b00, sz};
						if (grown > {2'b00, heap_limit}) begin
							r.status = ST_NOHEAP;
						end else if (blk_count >= MAX_BLOCKS) begin
							r.status = ST_FULL;
						end else begin
							blk_start[blk_count] = brk;
							blk_size[blk_count] = sz;
							blk_free[blk_count] = 1'b0;
							r.payload = payload_at(blk_count);
							blk_count++;
							brk = grown[31:0];
						end
					end
				end
			end else if (addr != 0) begin
				for (i = 0; i < blk_count; i++) begin
					if ({1'b0, blk_start[i]} + 33'(HEADER_BYTES) == {1'b0, addr}) begin
						hit = i;
						break;
					end
				end
				if (hit < 0) begin
					r.status = ST_UNKNOWN;
				end else if (hit == blk_count - 1) begin
					brk = blk_start[hit];
					blk_count = hit;
					r.shrank = 1'b1;
				end else begin
					blk_free[hit] = 1'b1;
				end
			end
			pending_results.push_back(r);
		endfunction

		function void flag(string msg);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(logic [31:0] data, logic [7:0] user);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				flag($sformatf("word with nothing expected: addr %h tuser %h", data, user));
				return;
			end
			want = pending_results.pop_front();
			if (data !== want.payload || user[2:0] !== want.status ||
			    user[3] !== want.shrank || user[7:4] !== 4'd0)
				flag($sformatf("expected addr %h status %0d shrank %0d, got addr %h tuser %h",
					want.payload, want.status, want.shrank, data, user));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [7:0]  m_axis_tuser;
	logic        heap_limit_we = 1'b0;
	logic [31:0] heap_limit_wdata = '0;

	alloc_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_off = 1'b0;

	first_fit_block_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.heap_limit_we(heap_limit_we),
		.heap_limit_wdata(heap_limit_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_word(input op_t op, input logic [31:0] sz, input logic [31:0] addr);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {addr, sz};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(op, sz, addr);
	endtask

	task automatic write_limit(input logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		heap_limit_we <= 1'b1;
		heap_limit_wdata <= value;
		@(posedge clk);
		heap_limit_we <= 1'b0;
		sb.heap_limit = value;
	endtask

	// mostly allocs and releases of live blocks, some noise words
	task automatic random_phase(input int count, input int alloc_pct, input int size_max);
		int          n;
		int          roll;
		int          pick;
		op_t         op;
		logic [31:0] sz;
		logic [31:0] addr;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			op = OP_ALLOC;
			sz = $urandom();
			addr = $urandom();
			if (roll < 8) begin
				op = op_t'($urandom_range(0, 1));
			end else if (roll < 8 + alloc_pct * 92 / 100) begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					sz = '0;
				else if (pick != 1)
					sz = $urandom_range(1, size_max);
			end else begin
				op = OP_RELEASE;
				pick = $urandom_range(0, 9);
				if (sb.blk_count == 0 || pick == 0)
					addr = $urandom_range(0, 1) ? 32'd0 : $urandom();
				else if (pick == 1)
					addr = sb.payload_at($urandom_range(0, sb.blk_count - 1)) + 32'd1;
				else if (pick <= 3)
					addr = sb.payload_at(sb.blk_count - 1);
				else
					addr = sb.payload_at($urandom_range(0, sb.blk_count - 1));
			end
			send_word(op, sz, addr);
		end
	endtask

	// result side with random backpressure and one long hold-off
	initial begin
		forever begin : rx_loop
			int stall;
			if (hold_off) begin
				hold_off = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 12);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_result(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_first_fit_block_allocator NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: null cases, reuse, pops, exact limit
		send_word(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
		send_word(OP_RELEASE, 32'hFFFF_FFFF, 32'd0);
		send_word(OP_RELEASE, 32'd0, 32'hFFFF_FFFF);
		send_word(OP_ALLOC, 32'd1, 32'd0);
		send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
		send_word(OP_ALLOC, 32'd100, 32'd0);
		send_word(OP_ALLOC, 32'd8, 32'd0);
		send_word(OP_RELEASE, 32'd0, sb.payload_at(1));
		send_word(OP_RELEASE, 32'd0, sb.payload_at(1));
		send_word(OP_ALLOC, 32'd50, 32'd0);
		send_word(OP_RELEASE, 32'd0, sb.payload_at(0) + 32'd1);
		send_word(OP_RELEASE, 32'd0, sb.payload_at(2));
		send_word(OP_RELEASE, 32'd0, sb.payload_at(1));
		send_word(OP_ALLOC, 32'd20, 32'd0);
		send_word(OP_RELEASE, 32'd0, sb.payload_at(0));
		send_word(OP_RELEASE, 32'd0, sb.payload_at(1));
		send_word(OP_RELEASE, 32'd0, sb.payload_at(0));
		send_word(OP_ALLOC, HEAP_LIMIT_RESET - 32'(HEADER_BYTES), 32'd0);
		send_word(OP_ALLOC, 32'd1, 32'd0);
		send_word(OP_RELEASE, 32'd0, sb.payload_at(0));
		send_word(OP_ALLOC, 32'h8000_0000, 32'd0);
		send_word(OP_RELEASE, 32'd0, 32'h8000_0000);

		random_phase(500, 60, 256);

		write_limit(32'hFFFF_FFFF);
		quiet = 1'b1;
		hold_off = 1'b1;
		random_phase(200, 70, 4096);
		quiet = 1'b0;
		random_phase(200, 70, 4096);

		// limit drops below the current break
		write_limit(32'd300);
		random_phase(300, 35, 64);

		write_limit(32'd0);
		random_phase(200, 50, 64);

		write_limit(HEAP_LIMIT_RESET);
		random_phase(500, 50, 64);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("tb_first_fit_block_allocator OK");
		else
			$display("tb_first_fit_block_allocator NOT OK");
		$finish;
	end

endmodule
